// ===== design/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types and codes for the static linked list engine: command and
// response beats, command and status codes, controller states.
// ----------------------------------------------------------------------------
package sll_pkg;

    // command codes
    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_LOCATE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    // fixed node roles: 0 is the null link, 1 is the list head, 2 is the first free node
    localparam int unsigned NULL_NODE  = 0;
    localparam int unsigned HEAD_NODE  = 1;
    localparam int unsigned FIRST_FREE = 2;

    localparam int unsigned POS_W  = 10;
    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] data_value;
    } sll_cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] removed_value;
        logic [POS_W-1:0]        found_position;
    } sll_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DEL_A,
        S_DEL_B,
        S_INS_A,
        S_INS_B,
        S_LOC_HEAD,
        S_LOC,
        S_DONE
    } sll_state_t;

endpackage

// ===== design/sll_ram.sv =====
// ----------------------------------------------------------------------------
// sll_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module sll_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/sll_ctrl.sv =====
// ----------------------------------------------------------------------------
// sll_ctrl
// Command sequencer: walks the link store one node per cycle, performs the
// read-modify-write of links and values, keeps the free chain head and
// holds the response register.
// ----------------------------------------------------------------------------
module sll_ctrl #(
    parameter int unsigned NODE_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  sll_pkg::sll_cmd_t             cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sll_pkg::sll_rsp_t             rsp,
    output logic                          link_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0] link_wr_addr,
    output logic [$clog2(NODE_COUNT)-1:0] link_wr_data,
    output logic [$clog2(NODE_COUNT)-1:0] link_rd_addr,
    input  logic [$clog2(NODE_COUNT)-1:0] link_rd_data,
    output logic                          val_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0] val_wr_addr,
    output logic [sll_pkg::DATA_W-1:0]    val_wr_data,
    output logic [$clog2(NODE_COUNT)-1:0] val_rd_addr,
    input  logic [sll_pkg::DATA_W-1:0]    val_rd_data
);

    localparam int unsigned IDX_W = $clog2(NODE_COUNT);
    localparam logic [IDX_W-1:0] NULL_IDX  = IDX_W'(sll_pkg::NULL_NODE);
    localparam logic [IDX_W-1:0] HEAD_IDX  = IDX_W'(sll_pkg::HEAD_NODE);
    localparam logic [IDX_W-1:0] FREE_IDX  = IDX_W'(sll_pkg::FIRST_FREE);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODE_COUNT - 1);

    sll_pkg::sll_state_t state_reg, state_next;

    logic [1:0]                 cmd_reg, cmd_next;
    logic [sll_pkg::POS_W-1:0]  rem_reg, rem_next;
    logic [sll_pkg::POS_W-1:0]  cnt_reg, cnt_next;
    logic [sll_pkg::DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]           cur_reg, cur_next;
    logic [IDX_W-1:0]           nxt_reg, nxt_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           free_reg, free_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    logic                       clr_init_reg, clr_init_next;
    sll_pkg::sll_rsp_t          res_reg, res_next;
    sll_pkg::sll_rsp_t          out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sll_pkg::S_CLEAR;
            clr_reg       <= '0;
            clr_init_reg  <= 1'b0;
            free_reg      <= FREE_IDX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_init_reg  <= clr_init_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
        j_reg   <= j_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        j_next         = j_reg;
        free_next      = free_reg;
        clr_next       = clr_reg;
        clr_init_next  = clr_init_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        cmd_stall    = (state_reg != sll_pkg::S_IDLE);
        link_wr_en   = 1'b0;
        link_wr_addr = cur_reg;
        link_wr_data = '0;
        link_rd_addr = cur_reg;
        val_wr_en    = 1'b0;
        val_wr_addr  = j_reg;
        val_wr_data  = val_reg;
        val_rd_addr  = cur_reg;

        case (state_reg)
            sll_pkg::S_CLEAR:
            begin
                // rebuild free chain, head node gets a null link
                link_wr_en   = 1'b1;
                link_wr_addr = clr_reg;
                if (clr_reg == HEAD_IDX || clr_reg == LAST_IDX)
                begin
                    link_wr_data = NULL_IDX;
                end
                else
                begin
                    link_wr_data = clr_reg + IDX_W'(1);
                end
                if (clr_reg == LAST_IDX)
                begin
                    state_next = clr_init_reg ? sll_pkg::S_DONE : sll_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            sll_pkg::S_IDLE:
            begin
                link_rd_addr = HEAD_IDX;
                if (cmd_valid)
                begin
                    cmd_next = cmd.command;
                    val_next = cmd.data_value;
                    rem_next = cmd.position - sll_pkg::POS_W'(1);
                    cur_next = HEAD_IDX;
                    res_next = '0;
                    case (cmd.command)
                        sll_pkg::CMD_INIT:
                        begin
                            clr_next      = '0;
                            clr_init_next = 1'b1;
                            free_next     = FREE_IDX;
                            state_next    = sll_pkg::S_CLEAR;
                        end
                        sll_pkg::CMD_LOCATE:
                        begin
                            state_next = sll_pkg::S_LOC_HEAD;
                        end
                        default:
                        begin
                            if (cmd.position == '0)
                            begin
                                res_next.status = sll_pkg::STAT_BADPOS;
                                state_next      = sll_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = sll_pkg::S_WALK;
                            end
                        end
                    endcase
                end
            end

            sll_pkg::S_WALK:
            begin
                // link_rd_data is the link of cur_reg
                if (rem_reg != '0)
                begin
                    if (link_rd_data == NULL_IDX)
                    begin
                        res_next.status = sll_pkg::STAT_BADPOS;
                        state_next      = sll_pkg::S_DONE;
                    end
                    else
                    begin
                        cur_next     = link_rd_data;
                        rem_next     = rem_reg - sll_pkg::POS_W'(1);
                        link_rd_addr = link_rd_data;
                    end
                end
                else
                begin
                    // cur_reg is the predecessor
                    nxt_next = link_rd_data;
                    if (cmd_reg == sll_pkg::CMD_DELETE)
                    begin
                        if (link_rd_data == NULL_IDX)
                        begin
                            res_next.status = sll_pkg::STAT_BADPOS;
                            state_next      = sll_pkg::S_DONE;
                        end
                        else
                        begin
                            j_next       = link_rd_data;
                            link_rd_addr = link_rd_data;
                            val_rd_addr  = link_rd_data;
                            state_next   = sll_pkg::S_DEL_A;
                        end
                    end
                    else if (free_reg == NULL_IDX)
                    begin
                        res_next.status = sll_pkg::STAT_FULL;
                        state_next      = sll_pkg::S_DONE;
                    end
                    else
                    begin
                        j_next       = free_reg;
                        link_rd_addr = free_reg;
                        state_next   = sll_pkg::S_INS_A;
                    end
                end
            end

            sll_pkg::S_DEL_A:
            begin
                // unlink victim from predecessor
                link_wr_en             = 1'b1;
                link_wr_addr           = cur_reg;
                link_wr_data           = link_rd_data;
                res_next.removed_value = val_rd_data;
                state_next             = sll_pkg::S_DEL_B;
            end

            sll_pkg::S_DEL_B:
            begin
                // push victim onto free chain
                link_wr_en   = 1'b1;
                link_wr_addr = j_reg;
                link_wr_data = free_reg;
                free_next    = j_reg;
                state_next   = sll_pkg::S_DONE;
            end

            sll_pkg::S_INS_A:
            begin
                // pop free node, fill it and point it at the old successor
                free_next    = link_rd_data;
                link_wr_en   = 1'b1;
                link_wr_addr = j_reg;
                link_wr_data = nxt_reg;
                val_wr_en    = 1'b1;
                state_next   = sll_pkg::S_INS_B;
            end

            sll_pkg::S_INS_B:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = j_reg;
                state_next   = sll_pkg::S_DONE;
            end

            sll_pkg::S_LOC_HEAD:
            begin
                if (link_rd_data == NULL_IDX)
                begin
                    state_next = sll_pkg::S_DONE;
                end
                else
                begin
                    cur_next     = link_rd_data;
                    cnt_next     = sll_pkg::POS_W'(1);
                    link_rd_addr = link_rd_data;
                    val_rd_addr  = link_rd_data;
                    state_next   = sll_pkg::S_LOC;
                end
            end

            sll_pkg::S_LOC:
            begin
                if (val_rd_data == val_reg)
                begin
                    res_next.found_position = cnt_reg;
                    state_next              = sll_pkg::S_DONE;
                end
                else if (link_rd_data == NULL_IDX)
                begin
                    state_next = sll_pkg::S_DONE;
                end
                else
                begin
                    cur_next     = link_rd_data;
                    cnt_next     = cnt_reg + sll_pkg::POS_W'(1);
                    link_rd_addr = link_rd_data;
                    val_rd_addr  = link_rd_data;
                end
            end

            sll_pkg::S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    clr_init_next  = 1'b0;
                    state_next     = sll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sll_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== design/static_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_top
// Singly linked list with a free chain, kept in an index-linked node store.
// ----------------------------------------------------------------------------
// flow: insert and delete walk to the predecessor, then rewrite links;
//   locate walks to a match or the tail; init sweeps the link store
// throughput: one command at a time, set by the one-node-per-cycle walk
//   through the link RAM read port; a new command is taken while the
//   previous response beat still waits in the output register
// reset: the link RAM is swept to build the free chain and an empty list;
//   no command beat is taken during that sweep
module static_linked_list_engine_top #(
    parameter int unsigned NODE_COUNT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sll_pkg::sll_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sll_pkg::sll_rsp_t rsp
);

    localparam int unsigned IDX_W = $clog2(NODE_COUNT);

    // link store port signals
    logic             link_wr_en;
    logic [IDX_W-1:0] link_wr_addr;
    logic [IDX_W-1:0] link_wr_data;
    logic [IDX_W-1:0] link_rd_addr;
    logic [IDX_W-1:0] link_rd_data;

    // value store port signals
    logic                       val_wr_en;
    logic [IDX_W-1:0]           val_wr_addr;
    logic [sll_pkg::DATA_W-1:0] val_wr_data;
    logic [IDX_W-1:0]           val_rd_addr;
    logic [sll_pkg::DATA_W-1:0] val_rd_data;

    // next-node links; entry 0 is never read, the free chain head lives in
    // a register inside the sequencer
    sll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // node payloads, written only on insert, never cleared
    sll_ram #(
        .WIDTH (sll_pkg::DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    // walk, read-modify-write and response beat register
    sll_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .link_rd_addr (link_rd_addr),
        .link_rd_data (link_rd_data),
        .val_wr_en    (val_wr_en),
        .val_wr_addr  (val_wr_addr),
        .val_wr_data  (val_wr_data),
        .val_rd_addr  (val_rd_addr),
        .val_rd_data  (val_rd_data)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the static linked list engine. A predictor keeps
// its own copy of the node store and of the free chain and works out the
// response to every command beat that the engine takes. Directed checks come
// first, then a long list with full-length walks, then a long random mix.
// The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned NODE_COUNT = 1024;
    localparam int unsigned IDX_W = $clog2(NODE_COUNT);
    localparam int unsigned CMD_W = $bits(sll_pkg::sll_cmd_t);
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(sll_pkg::NULL_NODE);
    localparam logic signed [sll_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [sll_pkg::DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
    localparam logic signed [sll_pkg::DATA_W-1:0] TAIL_MARK = 32'sh5a5a_a5a5;
    localparam int unsigned LONG_LEN = 120;
    localparam int unsigned RANDOM_BEATS = 425;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    sll_pkg::sll_cmd_t cmd;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    sll_pkg::sll_rsp_t rsp;

    static_linked_list_engine_top #(
        .NODE_COUNT(NODE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor state: our own node store, index 0 heads the free chain
    // and doubles as the null link
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]                  nxt     [NODE_COUNT];
    logic signed [sll_pkg::DATA_W-1:0] payload [NODE_COUNT];
    logic [IDX_W-1:0]                  list_head;
    int unsigned                       list_len;

    // responses still owed by the engine, oldest first
    sll_pkg::sll_rsp_t pending_rsp[$];
    int unsigned mismatch_count = 0;

    // sender burst bookkeeping
    int unsigned burst_left = 0;

    // value pool so that locates and duplicates actually hit
    logic signed [sll_pkg::DATA_W-1:0] value_pool [16];

    // empty list, every other node on the free chain, head taken from it
    function automatic void rebuild_free_chain();
        for (int i = 0; i < NODE_COUNT - 1; i++)
            nxt[i] = IDX_W'(i + 1);
        nxt[NODE_COUNT-1] = NULL_IDX;
        list_head = nxt[NULL_IDX];
        nxt[NULL_IDX] = nxt[list_head];
        nxt[list_head] = NULL_IDX;
        list_len = 0;
    endfunction

    // walk to the node just ahead of a 1-based position (head is 0)
    function automatic bit seek_before(input logic [sll_pkg::POS_W-1:0] pos,
                                       input bit need_next,
                                       output logic [IDX_W-1:0] pred);
        logic [IDX_W-1:0] walk;
        int               hops;
        int               steps;
        walk  = list_head;
        hops  = 0;
        steps = 0;
        pred  = NULL_IDX;
        if (pos == 0)
            return 1'b0;
        while (hops < int'(pos) - 1 && steps < NODE_COUNT)
        begin
            walk = nxt[walk];
            if (walk == NULL_IDX)
                return 1'b0;
            hops++;
            steps++;
        end
        if (hops != int'(pos) - 1)
            return 1'b0;
        if (need_next && nxt[walk] == NULL_IDX)
            return 1'b0;
        pred = walk;
        return 1'b1;
    endfunction

    // apply one command to the list copy and return the response it owes
    function automatic sll_pkg::sll_rsp_t apply_command(input sll_pkg::sll_cmd_t c);
        sll_pkg::sll_rsp_t         r;
        logic [IDX_W-1:0]          pred;
        logic [IDX_W-1:0]          node;
        logic [sll_pkg::POS_W-1:0] rank;
        int                        steps;
        r = '0;
        r.status = sll_pkg::STAT_OK;
        case (c.command)
            sll_pkg::CMD_INIT:
            begin
                rebuild_free_chain();
            end
            sll_pkg::CMD_INSERT:
            begin
                if (!seek_before(c.position, 1'b0, pred))
                    r.status = sll_pkg::STAT_BADPOS;
                else if (nxt[NULL_IDX] == NULL_IDX)
                    r.status = sll_pkg::STAT_FULL;
                else
                begin
                    node = nxt[NULL_IDX];
                    nxt[NULL_IDX] = nxt[node];
                    payload[node] = c.data_value;
                    nxt[node] = nxt[pred];
                    nxt[pred] = node;
                    list_len++;
                end
            end
            sll_pkg::CMD_DELETE:
            begin
                if (!seek_before(c.position, 1'b1, pred))
                    r.status = sll_pkg::STAT_BADPOS;
                else
                begin
                    node = nxt[pred];
                    nxt[pred] = nxt[node];
                    r.removed_value = payload[node];
                    nxt[node] = nxt[NULL_IDX];
                    nxt[NULL_IDX] = node;
                    list_len--;
                end
            end
            default:
            begin
                node  = nxt[list_head];
                rank  = sll_pkg::POS_W'(1);
                steps = 0;
                while (node != NULL_IDX && steps < NODE_COUNT)
                begin
                    if (payload[node] == c.data_value)
                    begin
                        r.found_position = rank;
                        break;
                    end
                    node = nxt[node];
                    rank++;
                    steps++;
                end
            end
        endcase
        return r;
    endfunction

    function automatic sll_pkg::sll_cmd_t make_cmd(input logic [1:0] op,
                                                   input int unsigned pos,
                                                   input logic signed [sll_pkg::DATA_W-1:0] value);
        sll_pkg::sll_cmd_t c;
        c.command    = op;
        c.position   = sll_pkg::POS_W'(pos);
        c.data_value = value;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // sender: one command beat, in bursts with random gaps between them;
    // returns at the edge that takes the beat, with valid still high
    // ------------------------------------------------------------------
    task automatic issue_cmd(input sll_pkg::sll_cmd_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            // idle gap, payload is junk while valid is low
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            cmd_valid <= 1'b0;
            cmd       <= CMD_W'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // beat taken at this edge: predict in acceptance order
        pending_rsp.push_back(apply_command(c));
        burst_left--;
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern and response check
    // ------------------------------------------------------------------
    int unsigned stall_span  = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_clock = 0;

    task automatic check_rsp(input sll_pkg::sll_rsp_t got);
        sll_pkg::sll_rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch($sformatf("response beat with nothing outstanding: %p", got));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value got %0d want %0d",
                                      got.removed_value, want.removed_value));
        if (got.found_position !== want.found_position)
            report_mismatch($sformatf("found_position got %0d want %0d",
                                      got.found_position, want.found_position));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            // pick a new stall flavor every so often
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(16, 400);
            end
            stall_span--;
            stall_clock++;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= stall_clock[2];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // directed: empty list corners, ends and middle, extremes of values,
    // bad positions, duplicates, init clearing the list
    // ------------------------------------------------------------------
    task automatic test_directed();
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, 0));           // locate on empty list
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1, 0));           // delete from empty list
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 0, 7));           // position zero
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 2, 7));           // past length+1
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 1, MOST_NEG));
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 2, MOST_POS));    // append at the tail
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 1, 0));           // new front
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 2, -1));          // middle
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, MOST_POS));
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 1023, -1));
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, 12345));       // absent value
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 1023, 1));        // far out of range
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 0, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 5, 0));           // one past the tail
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 4, 0));           // tail
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 3, -1));          // duplicate value
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, -1));          // first match wins
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1, 0));           // front
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1023, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_INIT, 1023, MOST_NEG));   // init drops the list
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, MOST_NEG));
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1, 0));
    endtask

    // ------------------------------------------------------------------
    // build a long list, walk it end to end, poke both ends
    // ------------------------------------------------------------------
    task automatic test_long_list();
        int unsigned len;
        issue_cmd(make_cmd(sll_pkg::CMD_INIT, 0, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 1, TAIL_MARK));
        // never insert at length+1, so the marker stays at the tail
        for (len = 1; len < LONG_LEN; len++)
            issue_cmd(make_cmd(sll_pkg::CMD_INSERT, $urandom_range(1, (len < 4) ? len : 4),
                               $urandom));
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, TAIL_MARK));   // walks the whole list
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, $urandom));
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1023, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, LONG_LEN, 0));    // tail
        issue_cmd(make_cmd(sll_pkg::CMD_DELETE, 1, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, LONG_LEN - 2, MOST_POS));
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, 1, MOST_NEG));
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, LONG_LEN + 1, 0)); // append at the tail
        issue_cmd(make_cmd(sll_pkg::CMD_INSERT, LONG_LEN + 3, 0)); // past length+1
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, MOST_POS));
        issue_cmd(make_cmd(sll_pkg::CMD_INIT, 0, 0));
        issue_cmd(make_cmd(sll_pkg::CMD_LOCATE, 0, MOST_NEG));
    endtask

    // ------------------------------------------------------------------
    // random mix: mostly valid positions so the list grows and shrinks,
    // some just past the end, zero, and anything in the field
    // ------------------------------------------------------------------
    task automatic test_random();
        int unsigned n;
        int unsigned pick;
        int unsigned ins_cut;
        int unsigned pos;
        logic [1:0]  op;
        logic signed [sll_pkg::DATA_W-1:0] value;
        value_pool[0] = MOST_NEG;
        value_pool[1] = MOST_POS;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int i = 4; i < 16; i++)
            value_pool[i] = $urandom;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            // keep the list at a few dozen nodes so walks stay short
            ins_cut = (list_len > 48) ? 25 : 47;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = sll_pkg::CMD_INIT;
            else if (pick < ins_cut)
                op = sll_pkg::CMD_INSERT;
            else if (pick < 72)
                op = sll_pkg::CMD_DELETE;
            else
                op = sll_pkg::CMD_LOCATE;
            pick = $urandom_range(0, 99);
            if (pick < 72)
                pos = (op == sll_pkg::CMD_INSERT) ? $urandom_range(1, list_len + 1)
                                                  : $urandom_range(1, (list_len > 0) ? list_len : 1);
            else if (pick < 82)
                pos = (op == sll_pkg::CMD_INSERT) ? list_len + 2 : list_len + 1;
            else if (pick < 90)
                pos = 0;
            else
                pos = $urandom_range(0, 1023);
            value = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 15)]
                                                : $urandom;
            issue_cmd(make_cmd(op, pos, value));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // the engine sweeps its link store after reset; the handshake waits
        rebuild_free_chain();
        for (int i = 0; i < NODE_COUNT; i++)
            payload[i] = '0;
        test_directed();
        test_long_list();
        test_random();
        cmd_valid <= 1'b0;
        // drain the outstanding responses, then watch for strays
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (NODE_COUNT + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // watchdog, far beyond the slowest legal run
    // ------------------------------------------------------------------
    initial
    begin
        #100000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== static_linked_list_engine_top.f =====
design/sll_pkg.sv
design/sll_ram.sv
design/sll_ctrl.sv
design/static_linked_list_engine_top.sv
tb/tb.sv
